/* src/chunk_resequencer_unit_macros.svh */
// Assertion macros shared by the chunk resequencer RTL.
`ifndef CHUNK_RESEQUENCER_UNIT_MACROS_SVH
`define CHUNK_RESEQUENCER_UNIT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define CRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/crs_pkg.sv */
// Types, widths and constants shared by the chunk resequencer modules.
package crs_pkg;

    // Field widths of the words on both channels.
    localparam int SEQ_W    = 31;
    localparam int SIZE_W   = 11;
    localparam int HANDLE_W = 16;
    localparam int LEFT_W   = 5;

    // Default reorder window and fixed limits.
    localparam int WINDOW_DEFAULT  = 16;
    localparam int MAX_CHUNK_BYTES = 1024;
    localparam int HANDLE_BITS     = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int LEFT_MAX        = 31;

    // Mask that keeps the meaningful bits of a payload handle.
    localparam logic [HANDLE_W-1:0] HANDLE_MASK = (HANDLE_BITS >= HANDLE_W) ? '1 :
        HANDLE_W'((1 << HANDLE_BITS) - 1);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_STALE    = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    // Kind of command handed from the front end to the back end.
    typedef enum logic {
        CMD_CHUNK = 1'b0,
        CMD_END   = 1'b1
    } cmd_kind_t;

    // One normalised command.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [SEQ_W-1:0]    seq;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

endpackage

/* src/chunk_resequencer_unit.sv */
// Top level of the chunk resequencer: front end, command queue and back end.
//
// Input channel (in_valid / in_stall): one word per chunk descriptor, or an
// end-of-transfer marker when op is high. Output channel (out_valid /
// out_stall): one word per released or dropped chunk, or one transfer-done
// word; last marks the final word caused by an input word.
// Path: the input word is registered in the front end, passes through the
// command queue, and the back end registers the result word.
// Throughput: while the receiver does not stall, the back end handles one
// command or one released chunk per cycle, so in-order traffic runs at one
// word per cycle; a parked out-of-order chunk gives no word.
// Reset empties the window and rearms at sequence 0; no clearing pass is
// needed. When the receiver stalls, the output word holds, the back end
// waits, the two-entry queue fills and in_stall rises.
`include "chunk_resequencer_unit_macros.svh"

module chunk_resequencer_unit import crs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic [SIZE_W-1:0]   chunk_size,
    input  logic [HANDLE_W-1:0] payload_handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [SEQ_W-1:0]    out_sequence,
    output logic [SIZE_W-1:0]   out_size,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [LEFT_W-1:0]   leftover_count,
    output logic                last
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic cmd_valid;
    cmd_t cmd;

    crs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .sequence_req   (sequence_req),
        .chunk_size     (chunk_size),
        .payload_handle (payload_handle),
        .push           (push),
        .push_cmd       (push_cmd),
        .q_full         (q_full)
    );

    crs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    crs_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_sequence   (out_sequence),
        .out_size       (out_size),
        .out_handle     (out_handle),
        .leftover_count (leftover_count),
        .last           (last)
    );

    // A drop or a transfer-done word always closes its input's results.
    `CRS_ASSERT_NOW(a_single_word_last, out_valid && status != ST_RELEASED, last, "drop or done word without last")

    // Only released chunks carry a size and a handle.
    `CRS_ASSERT_NOW(a_unused_zero, out_valid && status != ST_RELEASED, out_size == '0 && out_handle == '0, "non-release word carries payload")

    // Transfer-done words carry no sequence number.
    `CRS_ASSERT_NOW(a_done_seq_zero, out_valid && status == ST_DONE, out_sequence == '0, "done word with sequence")

    // Within a run the next released word follows at once with the next sequence.
    `CRS_ASSERT_NEXT(a_run_in_order, out_valid && !out_stall && status == ST_RELEASED && !last, out_valid && status == ST_RELEASED && out_sequence == SEQ_W'($past(out_sequence) + 1'b1), "release run broken")

endmodule

/* src/crs_front.sv */
// Front end: accepts input words and turns them into normalised commands.
module crs_front import crs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic [SIZE_W-1:0]   chunk_size,
    input  logic [HANDLE_W-1:0] payload_handle,
    output logic                push,
    output cmd_t                push_cmd,
    input  logic                q_full
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;
    logic [SIZE_W-1:0] size_sat;

    // The holding register only stalls the sender when the queue cannot take it.
    assign in_stall = hold_valid_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign push     = hold_valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    // Oversize chunks are clipped to the largest legal size.
    assign size_sat = (32'(chunk_size) > 32'(MAX_CHUNK_BYTES)) ?
        SIZE_W'(MAX_CHUNK_BYTES) : chunk_size;

    // Classify the word and normalise its fields.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        cmd_next        = cmd_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
            cmd_next.kind   = op ? CMD_END : CMD_CHUNK;
            cmd_next.seq    = sequence_req;
            cmd_next.size   = size_sat;
            cmd_next.handle = payload_handle & HANDLE_MASK;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

/* src/crs_queue.sv */
// Short command queue between the front end and the back end.
module crs_queue import crs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic cmd_valid,
    output cmd_t cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/crs_back.sv */
// Back end: window store, release sequencer and output register.
module crs_back import crs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [SEQ_W-1:0]    out_sequence,
    output logic [SIZE_W-1:0]   out_size,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [LEFT_W-1:0]   leftover_count,
    output logic                last
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int OCC_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = SIZE_W + HANDLE_W;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SEQ_W-1:0]    expected_reg;
    logic [SEQ_W-1:0]    expected_next;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [OCC_W-1:0]    count_reg;
    logic [OCC_W-1:0]    count_next;
    logic [WINDOW-1:0]   valid_reg;
    logic [WINDOW-1:0]   valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [SEQ_W-1:0]    seq_reg;
    logic [SEQ_W-1:0]    seq_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   size_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [LEFT_W-1:0]   left_reg;
    logic [LEFT_W-1:0]   left_next;
    logic                last_reg;
    logic                last_next;

    logic [SLOT_W-1:0]   slot_mem [WINDOW];
    logic [SLOT_W-1:0]   rd_data_reg;
    logic                wr_en;
    logic                rd_en;

    logic                out_free;
    logic [SEQ_W-1:0]    seq_gap;
    logic                is_stale;
    logic                is_beyond;
    logic [IDX_W:0]      slot_sum;
    logic [IDX_W-1:0]    ins_idx;
    logic [IDX_W-1:0]    head_inc;
    logic [SEQ_W-1:0]    expected_inc;
    logic [LEFT_W-1:0]   left_sat;

    // Classification against the current window.
    assign out_free     = !out_valid_reg || !out_stall;
    assign is_stale     = (cmd.seq < expected_reg);
    assign seq_gap      = cmd.seq - expected_reg;
    assign is_beyond    = (seq_gap >= SEQ_W'(WINDOW));
    assign slot_sum     = {1'b0, head_reg} + seq_gap[IDX_W:0];
    assign ins_idx      = (slot_sum >= (IDX_W + 1)'(WINDOW)) ?
        IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW)) : IDX_W'(slot_sum);
    assign head_inc     = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
    assign expected_inc = expected_reg + 1'b1;
    assign left_sat     = (32'(count_reg) > 32'(LEFT_MAX)) ?
        LEFT_W'(LEFT_MAX) : LEFT_W'(count_reg);

    // Sequencer: one command or one released chunk per cycle while the output register is free.
    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        seq_next       = seq_reg;
        size_next      = size_reg;
        handle_next    = handle_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    pop = 1'b1;
                    if (cmd.kind == CMD_END)
                    begin
                        // Report what is still held, then empty the window.
                        out_valid_next = 1'b1;
                        status_next    = ST_DONE;
                        seq_next       = '0;
                        size_next      = '0;
                        handle_next    = '0;
                        left_next      = left_sat;
                        last_next      = 1'b1;
                        expected_next  = '0;
                        head_next      = '0;
                        count_next     = '0;
                        valid_next     = '0;
                    end
                    else if (is_stale || is_beyond)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = is_stale ? ST_STALE : ST_BEYOND;
                        seq_next       = cmd.seq;
                        size_next      = '0;
                        handle_next    = '0;
                        left_next      = '0;
                        last_next      = 1'b1;
                    end
                    else if (seq_gap == '0)
                    begin
                        // The expected chunk goes straight out; look ahead at the next slot.
                        out_valid_next = 1'b1;
                        status_next    = ST_RELEASED;
                        seq_next       = expected_reg;
                        size_next      = cmd.size;
                        handle_next    = cmd.handle;
                        left_next      = '0;
                        expected_next  = expected_inc;
                        head_next      = head_inc;
                        if (valid_reg[head_inc])
                        begin
                            rd_en      = 1'b1;
                            last_next  = 1'b0;
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            last_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Out-of-order chunk is parked in its slot.
                        wr_en = 1'b1;
                        if (!valid_reg[ins_idx])
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        valid_next[ins_idx] = 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    status_next          = ST_RELEASED;
                    seq_next             = expected_reg;
                    size_next            = rd_data_reg[HANDLE_W +: SIZE_W];
                    handle_next          = rd_data_reg[HANDLE_W-1:0];
                    left_next            = '0;
                    valid_next[head_reg] = 1'b0;
                    count_next           = count_reg - 1'b1;
                    expected_next        = expected_inc;
                    head_next            = head_inc;
                    if (valid_reg[head_inc])
                    begin
                        rd_en     = 1'b1;
                        last_next = 1'b0;
                    end
                    else
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_RELEASED;
            seq_reg       <= '0;
            size_reg      <= '0;
            handle_reg    <= '0;
            left_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            seq_reg       <= seq_next;
            size_reg      <= size_next;
            handle_reg    <= handle_next;
            left_reg      <= left_next;
            last_reg      <= last_next;
        end
    end

    // Slot store for size and handle, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[ins_idx] <= {cmd.size, cmd.handle};
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[head_inc];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_sequence   = seq_reg;
    assign out_size       = size_reg;
    assign out_handle     = handle_reg;
    assign leftover_count = left_reg;
    assign last           = last_reg;

endmodule

/* tb/sv/chunk_resequencer_checker.sv */
`timescale 1ns / 100ps
// Checker for the chunk resequencer: watches both channels, predicts the result words and compares.
module chunk_resequencer_checker import crs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                op,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic [SIZE_W-1:0]   chunk_size,
    input  logic [HANDLE_W-1:0] payload_handle,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          status,
    input  logic [SEQ_W-1:0]    out_sequence,
    input  logic [SIZE_W-1:0]   out_size,
    input  logic [HANDLE_W-1:0] out_handle,
    input  logic [LEFT_W-1:0]   leftover_count,
    input  logic                last,
    output int                  fail_count,
    output int                  pending_count
);

    // One result word as the block should present it.
    typedef struct {
        status_t             status;
        logic [SEQ_W-1:0]    seq;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
        logic [LEFT_W-1:0]   left;
        logic                last;
    } outcome_t;

    // Shadow copy of the reorder window.
    logic [SEQ_W-1:0]    next_seq;
    int                  head_slot;
    logic                held_valid [WINDOW];
    logic [SIZE_W-1:0]   held_size [WINDOW];
    logic [HANDLE_W-1:0] held_handle [WINDOW];

    outcome_t outcome_queue [$];
    outcome_t seen;
    int       mismatches = 0;

    // Empty the window and rearm at sequence zero.
    task automatic clear_window();
        next_seq  = '0;
        head_slot = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            held_valid[i] = 1'b0;
        end
    endtask

    task automatic post_outcome(input status_t st, input logic [SEQ_W-1:0] seq,
                                input logic [SIZE_W-1:0] size,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [LEFT_W-1:0] left);
        outcome_t w;
        w.status = st;
        w.seq    = seq;
        w.size   = size;
        w.handle = handle;
        w.left   = left;
        w.last   = 1'b0;
        outcome_queue.push_back(w);
    endtask

    // Apply one accepted input word to the window and queue the words it causes.
    task automatic advance_window(input logic op_w, input logic [SEQ_W-1:0] seq_w,
                                  input logic [SIZE_W-1:0] size_w,
                                  input logic [HANDLE_W-1:0] handle_w);
        int               held;
        int               released;
        int               slot;
        logic [SEQ_W-1:0] offset;
        logic [SIZE_W-1:0] kept_size;
        held     = 0;
        released = 0;
        if (cmd_kind_t'(op_w) == CMD_END)
        begin
            // Count what is still parked, saturating, then start afresh.
            for (int i = 0; i < WINDOW; i++)
            begin
                if (held_valid[i] && held < LEFT_MAX)
                    held++;
            end
            clear_window();
            post_outcome(ST_DONE, '0, '0, '0, LEFT_W'(held));
            outcome_queue[outcome_queue.size() - 1].last = 1'b1;
        end
        else if (seq_w < next_seq)
        begin
            post_outcome(ST_STALE, seq_w, '0, '0, '0);
            outcome_queue[outcome_queue.size() - 1].last = 1'b1;
        end
        else
        begin
            offset = seq_w - next_seq;
            if (offset >= SEQ_W'(WINDOW))
            begin
                post_outcome(ST_BEYOND, seq_w, '0, '0, '0);
                outcome_queue[outcome_queue.size() - 1].last = 1'b1;
            end
            else
            begin
                // Park the chunk, oversize lengths clipped to the maximum.
                kept_size = (size_w > SIZE_W'(MAX_CHUNK_BYTES)) ?
                    SIZE_W'(MAX_CHUNK_BYTES) : size_w;
                slot = (head_slot + int'(offset)) % WINDOW;
                held_valid[slot]  = 1'b1;
                held_size[slot]   = kept_size;
                held_handle[slot] = handle_w & HANDLE_MASK;
                // Release the run of consecutive chunks from the head.
                while (released < WINDOW && held_valid[head_slot])
                begin
                    post_outcome(ST_RELEASED, next_seq, held_size[head_slot],
                                 held_handle[head_slot], '0);
                    held_valid[head_slot] = 1'b0;
                    released++;
                    next_seq  = next_seq + 1'b1;
                    head_slot = (head_slot + 1) % WINDOW;
                end
                if (released > 0)
                    outcome_queue[outcome_queue.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Compare result words first, then take in the input word of this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            outcome_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_queue.size() == 0)
                begin
                    $error("result word with nothing outstanding: status %0d sequence %0d",
                           status, out_sequence);
                    mismatches++;
                end
                else
                begin
                    seen = outcome_queue.pop_front();
                    check_field("status", seen.status, status);
                    check_field("out_sequence", seen.seq, out_sequence);
                    check_field("out_size", seen.size, out_size);
                    check_field("out_handle", seen.handle, out_handle);
                    check_field("leftover_count", seen.left, leftover_count);
                    check_field("last", seen.last, last);
                end
            end
            if (in_valid && !in_stall)
                advance_window(op, sequence_req, chunk_size, payload_handle);
        end
        fail_count    <= mismatches;
        pending_count <= outcome_queue.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the chunk resequencer testbench: clock, reset, stimulus, receiver and verdict.
module testbench import crs_pkg::*;
();

    localparam int WINDOW        = WINDOW_DEFAULT;
    localparam int RANDOM_ITEMS  = 80;
    localparam int IDLE_PCT      = 11;
    localparam int NOISE_PCT     = 15;
    localparam int HOLD_AT_ITEM  = 70;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    // Kinds of disruptive word mixed into the well-formed transfers.
    typedef enum int {
        NOISE_STALE  = 0,
        NOISE_BEYOND = 1,
        NOISE_REPEAT = 2,
        NOISE_RAW    = 3
    } noise_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [SEQ_W-1:0]    sequence_req;
    logic [SIZE_W-1:0]   chunk_size;
    logic [HANDLE_W-1:0] payload_handle;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [SEQ_W-1:0]    out_sequence;
    logic [SIZE_W-1:0]   out_size;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEFT_W-1:0]   leftover_count;
    logic                last;
    int                  fail_count;
    int                  pending_count;

    int   items_sent  = 0;
    int   cycle_count = 0;
    logic hold_taken  = 1'b0;

    chunk_resequencer_unit #(.WINDOW(WINDOW)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .sequence_req(sequence_req), .chunk_size(chunk_size),
        .payload_handle(payload_handle),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_sequence(out_sequence), .out_size(out_size),
        .out_handle(out_handle), .leftover_count(leftover_count), .last(last)
    );

    chunk_resequencer_checker #(.WINDOW(WINDOW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .sequence_req(sequence_req), .chunk_size(chunk_size),
        .payload_handle(payload_handle),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_sequence(out_sequence), .out_size(out_size),
        .out_handle(out_handle), .leftover_count(leftover_count), .last(last),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly in-range lengths, with a share of raw 11-bit values that need clipping.
    function automatic logic [SIZE_W-1:0] chunk_bytes();
        if ($urandom_range(3) == 0)
            return SIZE_W'($urandom);
        return SIZE_W'($urandom_range(MAX_CHUNK_BYTES));
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic offer_word(input cmd_kind_t kind, input logic [SEQ_W-1:0] seq,
                              input logic [SIZE_W-1:0] size,
                              input logic [HANDLE_W-1:0] handle);
        logic quiet_tx;
        quiet_tx = (items_sent >= 90 && items_sent < 125);
        if (!quiet_tx && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= kind;
        sequence_req   <= seq;
        chunk_size     <= size;
        payload_handle <= handle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // One disruptive word relative to the group that starts at base.
    task automatic offer_noise(input int unsigned base, input int unsigned fill);
        logic [SEQ_W-1:0] seq;
        cmd_kind_t        kind;
        kind = CMD_CHUNK;
        case (noise_t'($urandom_range(3)))
            NOISE_STALE:
                seq = (base > 0) ? SEQ_W'($urandom_range(base - 1)) :
                    SEQ_W'(base + $urandom_range(fill - 1));
            NOISE_BEYOND:
                seq = SEQ_W'(base + 2 * WINDOW + $urandom_range(4 * WINDOW));
            NOISE_REPEAT:
                seq = SEQ_W'(base + $urandom_range(fill - 1));
            default:
            begin
                kind = cmd_kind_t'($urandom_range(1));
                seq  = SEQ_W'($urandom);
            end
        endcase
        offer_word(kind, seq, chunk_bytes(), HANDLE_W'($urandom));
    endtask

    // A transfer: groups of a window each, shuffled, the last one of up to a window and
    // possibly with a hole, then the end-of-transfer word.
    task automatic run_transfer();
        int unsigned groups;
        int unsigned fill;
        int unsigned base;
        int unsigned pick;
        int unsigned tmp;
        int unsigned hole_seq;
        logic        has_hole;
        int unsigned order [WINDOW];
        groups = $urandom_range(1, 3);
        base   = 0;
        for (int g = 0; g < groups; g++)
        begin
            fill     = (g == groups - 1) ? $urandom_range(1, WINDOW) : WINDOW;
            has_hole = (g == groups - 1) && (fill > 1) && ($urandom_range(1) == 1);
            hole_seq = base + $urandom_range(fill - 1);
            for (int k = 0; k < fill; k++)
            begin
                order[k] = base + k;
            end
            for (int k = fill - 1; k > 0; k--)
            begin
                pick        = $urandom_range(k);
                tmp         = order[k];
                order[k]    = order[pick];
                order[pick] = tmp;
            end
            for (int k = 0; k < fill; k++)
            begin
                if ($urandom_range(99) < NOISE_PCT)
                    offer_noise(base, fill);
                if (!has_hole || order[k] != hole_seq)
                    offer_word(CMD_CHUNK, SEQ_W'(order[k]), chunk_bytes(),
                               HANDLE_W'($urandom));
            end
            base += fill;
        end
        offer_word(CMD_END, SEQ_W'($urandom), SIZE_W'($urandom), HANDLE_W'($urandom));
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_taken && items_sent >= HOLD_AT_ITEM)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !(items_sent >= 30 && items_sent < 60) &&
                ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Reset, directed words, random transfers, drain and verdict.
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        op             <= CMD_CHUNK;
        sequence_req   <= '0;
        chunk_size     <= '0;
        payload_handle <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End marker straight after reset, with junk in the ignored fields.
        offer_word(CMD_END, SEQ_W'($urandom), SIZE_W'($urandom), HANDLE_W'($urandom));
        // Field extremes on in-order chunks; the second is clipped to the maximum.
        offer_word(CMD_CHUNK, '0, '0, '0);
        offer_word(CMD_CHUNK, SEQ_W'(1), '1, '1);
        // Stale, far beyond, and just past the window edge.
        offer_word(CMD_CHUNK, '0, chunk_bytes(), HANDLE_W'($urandom));
        offer_word(CMD_CHUNK, '1, chunk_bytes(), HANDLE_W'($urandom));
        offer_word(CMD_CHUNK, SEQ_W'(2 + WINDOW), chunk_bytes(), HANDLE_W'($urandom));
        // Last slot of the window, then an overwrite of the same sequence.
        offer_word(CMD_CHUNK, SEQ_W'(1 + WINDOW), chunk_bytes(), HANDLE_W'($urandom));
        offer_word(CMD_CHUNK, SEQ_W'(1 + WINDOW), chunk_bytes(), HANDLE_W'($urandom));
        // Fill the window backwards so the final chunk releases all of it.
        for (int s = WINDOW; s >= 2; s--)
        begin
            offer_word(CMD_CHUNK, SEQ_W'(s), chunk_bytes(), HANDLE_W'($urandom));
        end
        // A parked chunk left behind by the end marker.
        offer_word(CMD_CHUNK, SEQ_W'(4 + WINDOW), chunk_bytes(), HANDLE_W'($urandom));
        offer_word(CMD_END, SEQ_W'($urandom), SIZE_W'($urandom), HANDLE_W'($urandom));

        while (items_sent < 25 + RANDOM_ITEMS)
            run_transfer();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
